// ----- sv/hbm_pkg.sv -----
// ----------------------------------------------------------------------------
// hbm_pkg: shared types and constants
// widths, reset values, codes and register indexes of the heartbeat monitor
// ----------------------------------------------------------------------------
package hbm_pkg;

  localparam int CHANNELS_DEF = 5;

  localparam int AGE_W  = 15;
  localparam int CHAN_W = 3;
  localparam int MASK_W = 5;

  localparam logic [AGE_W-1:0] AGE_MAX     = 15'd32767;
  localparam logic [AGE_W-1:0] LIMIT_RESET = 15'd1000;
  localparam int               LIMIT_REGS  = 5;

  // request opcodes
  localparam logic OP_TICK   = 1'b0;
  localparam logic OP_UPDATE = 1'b1;

  // event kinds
  localparam logic KIND_OKAY  = 1'b0;
  localparam logic KIND_ERROR = 1'b1;

  // apb
  localparam int PADDR_W = 5;
  localparam int PDATA_W = 32;
  localparam int REG_W   = 3;

  localparam logic [REG_W-1:0] REG_LIMIT_SPEED    = 3'd0;
  localparam logic [REG_W-1:0] REG_LIMIT_BATTERY  = 3'd1;
  localparam logic [REG_W-1:0] REG_LIMIT_INPUT    = 3'd2;
  localparam logic [REG_W-1:0] REG_LIMIT_SELECTOR = 3'd3;
  localparam logic [REG_W-1:0] REG_LIMIT_GEAR     = 3'd4;

  // what one lane found on a tick
  typedef struct packed {
    logic valid;
    logic kind;
  } hbm_ev_t;

endpackage

// ----- sv/hbm_if.sv -----
// ----------------------------------------------------------------------------
// hbm interfaces: request and event channels
// valid/ready channels carrying the request and event payloads
// ----------------------------------------------------------------------------
interface hbm_req_if;
  logic                      valid;
  logic                      ready;
  logic                      opcode;
  logic [hbm_pkg::CHAN_W-1:0] channel_index;
  logic [hbm_pkg::MASK_W-1:0] available_mask;

  modport source (output valid, opcode, channel_index, available_mask, input ready);
  modport sink   (input valid, opcode, channel_index, available_mask, output ready);
endinterface

interface hbm_evt_if;
  logic                      valid;
  logic                      ready;
  logic [hbm_pkg::CHAN_W-1:0] event_channel;
  logic                      event_kind;
  logic                      last_event;

  modport source (output valid, event_channel, event_kind, last_event, input ready);
  modport sink   (input valid, event_channel, event_kind, last_event, output ready);
endinterface

// ----- sv/hbm_lane.sv -----
// ----------------------------------------------------------------------------
// hbm_lane: one channel's age counter and health flag
// advances and checks the age on a tick, clears it on an update
// ----------------------------------------------------------------------------
module hbm_lane (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       tick,
  input  logic                       upd,
  input  logic                       avail,
  input  logic [hbm_pkg::AGE_W-1:0]  limit,
  output hbm_pkg::hbm_ev_t           ev
);
  import hbm_pkg::*;

  logic [AGE_W-1:0] age;
  logic             healthy;
  logic [AGE_W-1:0] age_inc;
  logic             over;

  // saturating advance, then compare against the limit
  assign age_inc = (age == AGE_MAX) ? age : age + 1'b1;
  assign over    = age_inc > limit;

  always_comb begin
    ev.valid = 1'b0;
    ev.kind  = KIND_OKAY;
    if (over && !avail) begin
      ev.valid = 1'b1;
      ev.kind  = KIND_ERROR;
    end else if (!over && !healthy) begin
      ev.valid = 1'b1;
      ev.kind  = KIND_OKAY;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      age     <= '0;
      healthy <= 1'b0;
    end else if (tick) begin
      age <= (over && avail) ? '0 : age_inc;
      if (over && !avail) begin
        healthy <= 1'b0;
      end else if (!over) begin
        healthy <= 1'b1;
      end
    end else if (upd) begin
      age <= '0;
    end
  end

endmodule

// ----- sv/hbm_merge.sv -----
// ----------------------------------------------------------------------------
// hbm_merge: event serializer
// queues per-tick lane findings and sends them lowest channel first
// ----------------------------------------------------------------------------
module hbm_merge #(
  parameter int CHANNELS = hbm_pkg::CHANNELS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  input  hbm_pkg::hbm_ev_t            ev [CHANNELS],
  output logic                        room,
  hbm_evt_if.source                   evt
);
  import hbm_pkg::*;

  logic                cur_valid;
  logic [CHANNELS-1:0] cur_mask;
  logic [CHANNELS-1:0] cur_kind;
  logic                pend_valid;
  logic [CHANNELS-1:0] pend_mask;
  logic [CHANNELS-1:0] pend_kind;

  logic [CHANNELS-1:0] push_mask;
  logic [CHANNELS-1:0] push_kind;
  logic [CHANNELS-1:0] sel;
  logic [CHANNELS-1:0] rest;
  logic [CHAN_W-1:0]   sel_ch;
  logic                sel_kind;
  logic                found;
  logic                load;
  logic                emit;
  logic                cur_free;

  always_comb begin
    for (int i = 0; i < CHANNELS; i++) begin
      push_mask[i] = ev[i].valid;
      push_kind[i] = ev[i].kind;
    end
  end

  // lowest pending channel of the current tick
  always_comb begin
    found    = 1'b0;
    sel      = '0;
    sel_ch   = '0;
    sel_kind = KIND_OKAY;
    for (int i = 0; i < CHANNELS; i++) begin
      if (cur_mask[i] && !found) begin
        found    = 1'b1;
        sel[i]   = 1'b1;
        sel_ch   = CHAN_W'(i);
        sel_kind = cur_kind[i];
      end
    end
  end

  assign rest     = cur_mask & ~sel;
  assign load     = !evt.valid || evt.ready;
  assign emit     = load && cur_valid;
  assign cur_free = !cur_valid || (emit && (rest == '0));
  assign room     = !pend_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid  <= 1'b0;
      pend_valid <= 1'b0;
    end else if (cur_free) begin
      if (pend_valid) begin
        cur_valid  <= 1'b1;
        cur_mask   <= pend_mask;
        cur_kind   <= pend_kind;
        pend_valid <= 1'b0;
      end else if (push) begin
        cur_valid <= 1'b1;
        cur_mask  <= push_mask;
        cur_kind  <= push_kind;
      end else begin
        cur_valid <= 1'b0;
      end
    end else begin
      if (emit) begin
        cur_mask <= rest;
      end
      if (push) begin
        pend_valid <= 1'b1;
        pend_mask  <= push_mask;
        pend_kind  <= push_kind;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      evt.valid <= 1'b0;
    end else if (emit) begin
      evt.valid <= 1'b1;
    end else if (evt.ready) begin
      evt.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      evt.event_channel <= sel_ch;
      evt.event_kind    <= sel_kind;
      evt.last_event    <= (rest == '0);
    end
  end

endmodule

// ----- sv/multi_channel_heartbeat_monitor.sv -----
// ----------------------------------------------------------------------------
// multi_channel_heartbeat_monitor: heartbeat watchdog over several channels
// per-channel age lanes, staleness limits over apb, serialized events
//
// usage:
//  - req channel: opcode update clears the age of channel_index (no event);
//    opcode tick ages every channel by one ms (saturating at 32767) and
//    checks them, available_mask giving which sources are reachable
//  - evt channel: one event per channel that recovers (okay) or is stale
//    and unreachable (error, repeated every tick), lowest channel first,
//    last_event marking the final event of a tick
//  - apb: five 15-bit staleness limits at byte addresses 0,4,..,16
//  - events: first event of a tick goes through the current-tick and output
//    registers, then one event per cycle while the receiver takes them
//  - throughput: a request can be accepted every cycle while req.ready is
//    high; the events of a tick leave one at a time through the single
//    output port of the event serializer, which sets the sustained rate
//  - receiver stall: events wait in the output register; one further
//    tick's findings queue behind the current one, then req.ready drops
//  - reset: ages zero, every channel down, limits 1000, queues empty
// ----------------------------------------------------------------------------
module multi_channel_heartbeat_monitor #(
  parameter int CHANNELS = hbm_pkg::CHANNELS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  hbm_req_if.sink                       req,
  hbm_evt_if.source                     evt,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [hbm_pkg::PADDR_W-1:0]   paddr,
  input  logic [hbm_pkg::PDATA_W-1:0]   pwdata,
  output logic [hbm_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready
);
  import hbm_pkg::*;

  logic [AGE_W-1:0] limit [LIMIT_REGS];
  logic [REG_W-1:0] reg_idx;
  logic             cfg_wr;
  logic             accept;
  logic             tick;
  logic             room;
  hbm_ev_t          ev [CHANNELS];
  logic             any_ev;

  // ---------------- configuration port ----------------
  assign pready  = 1'b1;
  assign reg_idx = paddr[PADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LIMIT_REGS; i++) begin
        limit[i] <= LIMIT_RESET;
      end
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_LIMIT_SPEED:    limit[0] <= pwdata[AGE_W-1:0];
        REG_LIMIT_BATTERY:  limit[1] <= pwdata[AGE_W-1:0];
        REG_LIMIT_INPUT:    limit[2] <= pwdata[AGE_W-1:0];
        REG_LIMIT_SELECTOR: limit[3] <= pwdata[AGE_W-1:0];
        REG_LIMIT_GEAR:     limit[4] <= pwdata[AGE_W-1:0];
        default: ;  // unknown register, write dropped
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_LIMIT_SPEED:    prdata = PDATA_W'(limit[0]);
      REG_LIMIT_BATTERY:  prdata = PDATA_W'(limit[1]);
      REG_LIMIT_INPUT:    prdata = PDATA_W'(limit[2]);
      REG_LIMIT_SELECTOR: prdata = PDATA_W'(limit[3]);
      REG_LIMIT_GEAR:     prdata = PDATA_W'(limit[4]);
      default:            prdata = '0;
    endcase
  end

  // ---------------- request side ----------------
  // requests are held off only while a whole tick's findings already wait
  assign req.ready = room;
  assign accept    = req.valid && req.ready;
  assign tick      = accept && (req.opcode == OP_TICK);

  // ---------------- lanes, one per channel ----------------
  for (genvar g = 0; g < CHANNELS; g++) begin : g_lane
    logic             upd;
    logic             avail;
    logic [AGE_W-1:0] lane_limit;

    assign upd = accept && (req.opcode == OP_UPDATE) &&
                 (32'(req.channel_index) == 32'(g));

    // channels without a limit register keep the reset limit and count
    // as unreachable
    if (g < LIMIT_REGS) begin : g_cfg
      assign avail      = req.available_mask[g];
      assign lane_limit = limit[g];
    end else begin : g_fixed
      assign avail      = 1'b0;
      assign lane_limit = LIMIT_RESET;
    end

    hbm_lane u_lane (
      .clk   (clk),
      .rst   (rst),
      .tick  (tick),
      .upd   (upd),
      .avail (avail),
      .limit (lane_limit),
      .ev    (ev[g])
    );
  end

  // a tick with no findings is not queued
  always_comb begin
    any_ev = 1'b0;
    for (int i = 0; i < CHANNELS; i++) begin
      any_ev = any_ev | ev[i].valid;
    end
  end

  // ---------------- merge and serialize ----------------
  hbm_merge #(
    .CHANNELS (CHANNELS)
  ) u_merge (
    .clk  (clk),
    .rst  (rst),
    .push (tick && any_ev),
    .ev   (ev),
    .room (room),
    .evt  (evt)
  );

endmodule
